@@ src/cnpm_pkg.sv @@
// Package for the cross-neighborhood pattern matcher.
// Holds the register map, the fixed field widths and the reset values.
// No dependencies.
package cnpm_pkg;

  localparam int ROW_W      = 12;
  localparam int GRID_COL_W = 7;
  localparam int OUT_COL_W  = 7;
  localparam int CODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS  = 3'd0,
    REG_GRID_COLS  = 3'd1,
    REG_SIDE_CODE  = 3'd2,
    REG_ABOVE_CODE = 3'd3,
    REG_BELOW_CODE = 3'd4
  } cfg_reg_e;

  localparam logic [ROW_W-1:0]      RST_GRID_ROWS  = 12'd3;
  localparam logic [GRID_COL_W-1:0] RST_GRID_COLS  = 7'd3;
  localparam logic [CODE_W-1:0]     RST_SIDE_CODE  = 4'd2;
  localparam logic [CODE_W-1:0]     RST_ABOVE_CODE = 4'd3;
  localparam logic [CODE_W-1:0]     RST_BELOW_CODE = 4'd1;

endpackage

@@ src/cnpm_if.sv @@
// Valid/ready channel interfaces of the pattern matcher: cells in, results out,
// register writes. Depends on cnpm_pkg for field widths.
interface cnpm_cell_if #(
  parameter int CELL_BITS = 4
);
  logic                 valid;
  logic                 ready;
  logic [CELL_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface cnpm_res_if;
  logic                           valid;
  logic                           ready;
  logic [cnpm_pkg::ROW_W-1:0]     match_row;
  logic [cnpm_pkg::OUT_COL_W-1:0] match_col;
  logic                           is_match;
  logic                           frame_done;

  modport source (output valid, output match_row, output match_col, output is_match,
                  output frame_done, input ready);
  modport sink (input valid, input match_row, input match_col, input is_match,
                input frame_done, output ready);
endinterface

interface cnpm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cnpm_pkg::CFG_IDX_W-1:0]  index;
  logic [cnpm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/cross_neighborhood_pattern_match.sv @@
// Top level of the cross-neighborhood pattern matcher.
// Depends on cnpm_pkg and the channel interfaces in cnpm_if.sv.
//
// Usage:
//   cell_i  : grid cells in raster order, one word per cell.
//   res_o   : result words; a match carries the 1-based row and column of the
//             center cell, the last cell of the grid gives a frame_done word.
//             Cells that cause neither produce no word.
//   cfg_i   : register writes (grid_rows, grid_cols, side/above/below codes),
//             always ready; write only while no cell is in flight.
// Throughput is one cell per clock unless a result stalls. Both line buffers
// share one memory of MAX_COLS entries, written and read once per accepted
// cell; the read for the next column is issued with the write of the current one.
// Each result word passes through the compare stage and then the output register.
// A stalled receiver holds the output register; cells without a result keep
// flowing, and cell_i.ready drops once a second word waits in the compare stage.
// Reset clears the position counters and loads the register defaults
// (3 x 3 grid, codes 2, 3, 1); buffer contents are not cleared and only rows
// already received are ever compared.
module cross_neighborhood_pattern_match #(
  parameter int MAX_COLS  = 64,
  parameter int CELL_BITS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cnpm_cfg_if.sink       cfg_i,
  cnpm_cell_if.sink      cell_i,
  cnpm_res_if.source     res_o
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int EW = ((CW > cnpm_pkg::GRID_COL_W) ? CW : cnpm_pkg::GRID_COL_W) + 1;
  localparam int RW = cnpm_pkg::ROW_W;

  // registers
  logic [RW-1:0]                   grid_rows_q;
  logic [cnpm_pkg::GRID_COL_W-1:0] grid_cols_q;
  logic [CELL_BITS-1:0]            side_code_q, above_code_q, below_code_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q  <= cnpm_pkg::RST_GRID_ROWS;
      grid_cols_q  <= cnpm_pkg::RST_GRID_COLS;
      side_code_q  <= CELL_BITS'(cnpm_pkg::RST_SIDE_CODE);
      above_code_q <= CELL_BITS'(cnpm_pkg::RST_ABOVE_CODE);
      below_code_q <= CELL_BITS'(cnpm_pkg::RST_BELOW_CODE);
    end else if (cfg_i.valid) begin
      case (cnpm_pkg::cfg_reg_e'(cfg_i.index))
        cnpm_pkg::REG_GRID_ROWS:  grid_rows_q  <= cfg_i.data[RW-1:0];
        cnpm_pkg::REG_GRID_COLS:  grid_cols_q  <= cfg_i.data[cnpm_pkg::GRID_COL_W-1:0];
        cnpm_pkg::REG_SIDE_CODE:  side_code_q  <= cfg_i.data[CELL_BITS-1:0];
        cnpm_pkg::REG_ABOVE_CODE: above_code_q <= cfg_i.data[CELL_BITS-1:0];
        cnpm_pkg::REG_BELOW_CODE: below_code_q <= cfg_i.data[CELL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [RW-1:0] rows_eff;
  logic [EW-1:0] cols_eff;

  always_comb begin
    rows_eff = (grid_rows_q == '0) ? RW'(1) : grid_rows_q;
    if (grid_cols_q == '0) begin
      cols_eff = EW'(1);
    end else if (EW'(grid_cols_q) > EW'(MAX_COLS)) begin
      cols_eff = EW'(MAX_COLS);
    end else begin
      cols_eff = EW'(grid_cols_q);
    end
  end

  // position counters
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          last_col, last_row;
  logic          in_acc;

  assign in_acc   = cell_i.valid && cell_i.ready;
  assign last_col = (EW'(col_q) + EW'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_q} + (RW+1)'(1)) >= {1'b0, rows_eff};

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // line buffer memory: entry = {row two above, row above}
  logic [2*CELL_BITS-1:0] lbuf [MAX_COLS];
  logic [2*CELL_BITS-1:0] rdata_q, wdata, wdata_q, ent_cur;
  logic [CW-1:0]          raddr;
  logic                   fwd_q;

  assign raddr   = last_col ? '0 : col_q + CW'(1);
  assign ent_cur = fwd_q ? wdata_q : rdata_q;
  assign wdata   = {ent_cur[CELL_BITS-1:0], cell_i.cell_value};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lbuf[col_q] <= wdata;
      rdata_q     <= lbuf[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= (raddr == col_q);
    end
  end

  // compare stage
  logic                 s1_v_q, s1_chk_q, s1_done_q;
  logic [CELL_BITS-1:0] s1_cell_q, s1_above_q, s1_left_q, left_hold_q;
  logic [RW-1:0]        s1_row_q;
  logic [CW-1:0]        s1_col_q;
  logic                 chk;

  assign chk = (row_q >= RW'(2)) && (col_q != '0) && ((EW'(col_q) + EW'(2)) <= cols_eff);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wdata_q     <= wdata;
      s1_cell_q   <= cell_i.cell_value;
      s1_above_q  <= ent_cur[2*CELL_BITS-1:CELL_BITS];
      s1_left_q   <= left_hold_q;
      left_hold_q <= ent_cur[CELL_BITS-1:0];
      s1_row_q    <= row_q;
      s1_col_q    <= col_q;
    end
  end

  logic s1_match, s1_has_res, s1_go, out_free;
  logic out_valid_q;

  assign s1_match = s1_chk_q
                 && (s1_left_q == side_code_q)
                 && (ent_cur[CELL_BITS-1:0] == side_code_q)
                 && (s1_above_q == above_code_q)
                 && (s1_cell_q == below_code_q);
  assign s1_has_res   = s1_match || s1_done_q;
  assign out_free     = !out_valid_q || res_o.ready;
  assign s1_go        = !s1_has_res || out_free;
  assign cell_i.ready = !s1_v_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_chk_q  <= 1'b0;
      s1_done_q <= 1'b0;
    end else if (cell_i.ready) begin
      s1_v_q    <= cell_i.valid;
      s1_chk_q  <= cell_i.valid && chk;
      s1_done_q <= cell_i.valid && last_col && last_row;
    end
  end

  // output register
  logic [RW-1:0]                  out_row_q;
  logic [cnpm_pkg::OUT_COL_W-1:0] out_col_q;
  logic                           out_match_q, out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_v_q && s1_has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_match_q <= s1_match;
      out_done_q  <= s1_done_q && !s1_match;
      out_row_q   <= s1_match ? s1_row_q : '0;
      out_col_q   <= s1_match ? cnpm_pkg::OUT_COL_W'(EW'(s1_col_q) + EW'(1)) : '0;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.match_row  = out_row_q;
  assign res_o.match_col  = out_col_q;
  assign res_o.is_match   = out_match_q;
  assign res_o.frame_done = out_done_q;

endmodule

@@ src/cnpm_checker.sv @@
// Port-level checks for cross_neighborhood_pattern_match, bound to the top level.
// Depends on cnpm_pkg for field widths.
module cnpm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [cnpm_pkg::ROW_W-1:0]     match_row_i,
  input logic [cnpm_pkg::OUT_COL_W-1:0] match_col_i,
  input logic                           is_match_i,
  input logic                           frame_done_i
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(match_row_i)
      && $stable(match_col_i) && $stable(is_match_i) && $stable(frame_done_i))
    else $error("result word changed while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_match_i != frame_done_i))
    else $error("word must be exactly one of match or frame_done");

  // a center is interior: never in the first row or column
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_match_i |-> (match_row_i >= 2) && (match_col_i >= 2))
    else $error("match reported on a border cell");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> (match_row_i == '0) && (match_col_i == '0))
    else $error("frame_done word carries a position");

endmodule

bind cross_neighborhood_pattern_match cnpm_checker u_cnpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .match_row_i  (res_o.match_row),
  .match_col_i  (res_o.match_col),
  .is_match_i   (res_o.is_match),
  .frame_done_i (res_o.frame_done)
);
